### design/ssml_tag_escape_stream_core_macros.svh
// assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef SSML_TAG_ESCAPE_STREAM_CORE_MACROS_SVH
`define SSML_TAG_ESCAPE_STREAM_CORE_MACROS_SVH

// cond must hold at every edge
`define STE_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ste check failed");

// when trig holds, cond must hold at the same edge
`define STE_ASSERT_IMP(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("ste check failed");

`endif

### design/ste_pkg.sv
package ste_pkg;

  localparam int MaxRes = 7;
  localparam int CntW = $clog2(MaxRes + 1);
  localparam int QueueDepthDef = 2;

  // one input transaction worth of output bytes
  typedef struct packed {
    logic [MaxRes-1:0][7:0] data;
    logic [CntW-1:0]        cnt;
    logic                   last;
  } job_t;

endpackage

### design/ste_front.sv
module ste_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic            q_full,
  output logic            push,
  output ste_pkg::job_t   push_job
);

  localparam logic [3:0] EP_NONE = 4'd0;
  localparam logic [3:0] EP_AMP  = 4'd1;
  localparam logic [3:0] EP_Q    = 4'd2;
  localparam logic [3:0] EP_QU   = 4'd3;
  localparam logic [3:0] EP_QUO  = 4'd4;
  localparam logic [3:0] EP_A    = 4'd5;
  localparam logic [3:0] EP_AP   = 4'd6;
  localparam logic [3:0] EP_APO  = 4'd7;
  localparam logic [3:0] EP_AM   = 4'd8;
  localparam logic [3:0] EP_L    = 4'd9;
  localparam logic [3:0] EP_G    = 4'd10;
  localparam logic [3:0] EP_LT   = 4'd11;
  localparam logic [3:0] EP_GT   = 4'd12;

  localparam logic [7:0] CH_ESC  = 8'hEE;
  localparam logic [7:0] CH_HI   = 8'h80;
  localparam logic [7:0] CH_LOW6 = 8'h3F;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [1:0] {
    ADV_MISS = 2'd0,
    ADV_NEXT = 2'd1,
    ADV_DONE = 2'd2
  } adv_kind_t;

  typedef struct packed {
    adv_kind_t  kind;
    logic [3:0] code;
    logic [7:0] ch;
  } adv_t;

  function automatic adv_t advance(input logic [3:0] code, input logic [7:0] b);
    adv_t r;
    r = '{kind: ADV_MISS, code: EP_NONE, ch: 8'h00};
    unique case (code)
      EP_AMP: begin
        if (b == "q") r = '{kind: ADV_NEXT, code: EP_Q, ch: 8'h00};
        else if (b == "a") r = '{kind: ADV_NEXT, code: EP_A, ch: 8'h00};
        else if (b == "l") r = '{kind: ADV_NEXT, code: EP_L, ch: 8'h00};
        else if (b == "g") r = '{kind: ADV_NEXT, code: EP_G, ch: 8'h00};
      end
      EP_Q:   if (b == "u") r = '{kind: ADV_NEXT, code: EP_QU, ch: 8'h00};
      EP_QU:  if (b == "o") r = '{kind: ADV_NEXT, code: EP_QUO, ch: 8'h00};
      EP_QUO: if (b == CH_SEMI) r = '{kind: ADV_DONE, code: EP_NONE, ch: CH_DQ};
      EP_A: begin
        if (b == "p") r = '{kind: ADV_NEXT, code: EP_AP, ch: 8'h00};
        else if (b == "m") r = '{kind: ADV_NEXT, code: EP_AM, ch: 8'h00};
      end
      EP_AP:  if (b == "o") r = '{kind: ADV_NEXT, code: EP_APO, ch: 8'h00};
      EP_APO: if (b == CH_SEMI) r = '{kind: ADV_DONE, code: EP_NONE, ch: CH_SQ};
      EP_AM:  if (b == CH_SEMI) r = '{kind: ADV_DONE, code: EP_NONE, ch: CH_AMP};
      EP_L:   if (b == "t") r = '{kind: ADV_NEXT, code: EP_LT, ch: 8'h00};
      EP_G:   if (b == "t") r = '{kind: ADV_NEXT, code: EP_GT, ch: 8'h00};
      EP_LT:  if (b == CH_SEMI) r = '{kind: ADV_DONE, code: EP_NONE, ch: CH_LT};
      EP_GT:  if (b == CH_SEMI) r = '{kind: ADV_DONE, code: EP_NONE, ch: CH_GT};
      default: r = '{kind: ADV_MISS, code: EP_NONE, ch: 8'h00};
    endcase
    return r;
  endfunction

  function automatic logic [3:0][7:0] prefix_text(input logic [3:0] code);
    logic [3:0][7:0] s;
    unique case (code)
      EP_AMP: s = {"&", 24'h0};
      EP_Q:   s = {"&q", 16'h0};
      EP_QU:  s = {"&qu", 8'h0};
      EP_QUO: s = "&quo";
      EP_A:   s = {"&a", 16'h0};
      EP_AP:  s = {"&ap", 8'h0};
      EP_APO: s = "&apo";
      EP_AM:  s = {"&am", 8'h0};
      EP_L:   s = {"&l", 16'h0};
      EP_G:   s = {"&g", 16'h0};
      EP_LT:  s = {"&lt", 8'h0};
      EP_GT:  s = {"&gt", 8'h0};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] prefix_len(input logic [3:0] code);
    logic [3:0] n;
    unique case (code)
      EP_AMP: n = 4'd1;
      EP_Q, EP_A, EP_L, EP_G: n = 4'd2;
      EP_QU, EP_AP, EP_AM, EP_LT, EP_GT: n = 4'd3;
      EP_QUO, EP_APO: n = 4'd4;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  logic [3:0] ep_r, ep_nxt;
  logic [1:0] skip_r, skip_nxt;
  logic       tag_r, tag_nxt;
  logic       sq_r, sq_nxt;
  logic       dq_r, dq_nxt;

  logic            accept;
  adv_t            adv;
  logic            do_fresh;
  logic            tag_expand;
  logic [3:0]      head_code;
  logic [3:0]      tail_code;
  logic [2:0][7:0] mid;
  logic [3:0]      mid_len;
  logic [3:0]      head_len;
  logic [3:0]      tail_len;
  logic [3:0]      total_len;
  logic [3:0][7:0] head_txt;
  logic [3:0][7:0] tail_txt;

  assign in_tready = !q_full;
  assign accept = in_tvalid && in_tready;
  assign adv = advance(ep_r, in_tdata);

  always_comb begin
    skip_nxt   = skip_r;
    ep_nxt     = ep_r;
    tag_nxt    = tag_r;
    sq_nxt     = sq_r;
    dq_nxt     = dq_r;
    head_code  = EP_NONE;
    mid        = '0;
    mid_len    = 4'd0;
    do_fresh   = 1'b0;
    tag_expand = 1'b0;

    if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else if (ep_r != EP_NONE && ep_r <= EP_GT) begin
      unique case (adv.kind)
        ADV_DONE: begin
          mid[0]  = adv.ch;
          mid_len = 4'd1;
          ep_nxt  = EP_NONE;
        end
        ADV_NEXT: ep_nxt = adv.code;
        default: begin
          head_code = ep_r;
          ep_nxt    = EP_NONE;
          do_fresh  = 1'b1;
        end
      endcase
    end else begin
      ep_nxt   = EP_NONE;
      do_fresh = 1'b1;
    end

    if (do_fresh) begin
      priority if (in_tdata == CH_ESC) begin
        skip_nxt = 2'd2;
      end else if (!tag_r && in_tdata == CH_LT) begin
        tag_nxt    = 1'b1;
        tag_expand = 1'b1;
      end else if (!tag_r && in_tdata == CH_AMP) begin
        ep_nxt = EP_AMP;
      end else if (!tag_r) begin
        mid[0]  = in_tdata;
        mid_len = 4'd1;
      end else begin
        tag_expand = 1'b1;
      end
    end

    if (tag_expand) begin
      mid[0]  = CH_ESC;
      mid[1]  = CH_HI | {6'd0, in_tdata[7:6]};
      mid[2]  = CH_HI | (in_tdata & CH_LOW6);
      mid_len = 4'd3;
      priority if (sq_r) begin
        if (in_tdata == CH_SQ) sq_nxt = 1'b0;
      end else if (dq_r) begin
        if (in_tdata == CH_DQ) dq_nxt = 1'b0;
      end else if (in_tdata == CH_SQ) begin
        sq_nxt = 1'b1;
      end else if (in_tdata == CH_DQ) begin
        dq_nxt = 1'b1;
      end else begin
        if (in_tdata == CH_GT) tag_nxt = 1'b0;
      end
    end

    tail_code = in_tlast ? ep_nxt : EP_NONE;

    if (in_tlast) begin
      ep_nxt   = EP_NONE;
      skip_nxt = 2'd0;
      tag_nxt  = 1'b0;
      sq_nxt   = 1'b0;
      dq_nxt   = 1'b0;
    end
  end

  assign head_len  = prefix_len(head_code);
  assign tail_len  = prefix_len(tail_code);
  assign head_txt  = prefix_text(head_code);
  assign tail_txt  = prefix_text(tail_code);
  assign total_len = head_len + mid_len + tail_len;

  // splice flushed prefix, fresh bytes and end-of-text flush
  always_comb begin
    push_job.cnt  = total_len[ste_pkg::CntW-1:0];
    push_job.last = in_tlast;
    for (int k = 0; k < ste_pkg::MaxRes; k++) begin
      logic [3:0] kk;
      logic [3:0] km;
      logic [3:0] kt;
      kk = 4'(k);
      km = kk - head_len;
      kt = km - mid_len;
      if (kk < head_len) push_job.data[k] = head_txt[2'd3 - kk[1:0]];
      else if (km < mid_len) push_job.data[k] = mid[km[1:0]];
      else push_job.data[k] = tail_txt[2'd3 - kt[1:0]];
    end
  end

  assign push = accept && (total_len != 4'd0 || in_tlast);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ep_r   <= EP_NONE;
      skip_r <= 2'd0;
      tag_r  <= 1'b0;
      sq_r   <= 1'b0;
      dq_r   <= 1'b0;
    end else if (accept) begin
      ep_r   <= ep_nxt;
      skip_r <= skip_nxt;
      tag_r  <= tag_nxt;
      sq_r   <= sq_nxt;
      dq_r   <= dq_nxt;
    end
  end

endmodule

### design/ste_queue.sv
`include "ssml_tag_escape_stream_core_macros.svh"

module ste_queue #(
  parameter int Depth = ste_pkg::QueueDepthDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ste_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output ste_pkg::job_t head_job
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  ste_pkg::job_t   mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full       = (count_r == CntW'(Depth));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop) rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  `STE_ASSERT_IMP(a_no_push_when_full, full, !push)
  `STE_ASSERT_IMP(a_no_pop_when_empty, !head_valid, !pop)
  `STE_ASSERT_ALWAYS(a_count_in_range, count_r <= CntW'(Depth))

endmodule

### design/ste_back.sv
`include "ssml_tag_escape_stream_core_macros.svh"

module ste_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  ste_pkg::job_t head_job,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast,
  output logic [1:0]    out_tuser
);

  ste_pkg::job_t              work_r;
  logic                       work_v_r;
  logic [ste_pkg::CntW-1:0]   idx_r;
  logic [ste_pkg::CntW-1:0]   nres;
  logic                       load;
  logic                       fin;
  logic                       out_v_r;
  logic [7:0]                 byte_r;
  logic                       flag_r;
  logic                       last_r;
  logic                       done_r;

  assign nres = (work_r.cnt == '0) ? ste_pkg::CntW'(1) : work_r.cnt;
  assign fin  = (idx_r == nres - 1'b1);
  assign load = work_v_r && (!out_v_r || out_tready);
  assign pop  = head_valid && (!work_v_r || (load && fin));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (pop) work_v_r <= 1'b1;
      else if (load && fin) work_v_r <= 1'b0;
      if (load) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work_r <= head_job;
      idx_r  <= '0;
    end else if (load) begin
      idx_r <= idx_r + 1'b1;
    end
    if (load) begin
      byte_r <= (work_r.cnt == '0) ? 8'h00 : work_r.data[idx_r];
      flag_r <= (work_r.cnt != '0);
      last_r <= fin;
      done_r <= fin && work_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = {done_r, flag_r};

  `STE_ASSERT_IMP(a_done_ends_run, out_v_r && done_r, last_r)
  `STE_ASSERT_IMP(a_bare_marker_ends_text, out_v_r && !flag_r,
                  last_r && done_r && byte_r == 8'h00)
  `STE_ASSERT_IMP(a_idx_within_job, work_v_r, idx_r < nres)

endmodule

### design/ssml_tag_escape_stream_core.sv
// Streaming tag escaper: takes one text byte per transaction on in_* and
// returns the escaped bytes on out_*, one per transaction. Entities outside a
// tag are decoded, bytes inside a tag come out as three bytes each, and an
// escape byte with the two that follow it is dropped. The front end accepts
// one input byte per cycle while the queue is not full, and writes the whole
// set of output bytes of that byte into a queue of QueueDepth entries; the
// back end sends one output byte per cycle while out_tready is high. Sustained
// rate is therefore set by the output side: one output byte for a plain or
// decoded byte, three for a tag byte, up to seven when a held entity prefix
// is flushed, and none for a byte that is only held or dropped. A byte that
// ends the text (in_tlast) always gives at least one output transaction; if
// it has no data, a bare end marker with out_tuser[0] low is sent. A byte
// passes through the queue, the work register and the output register.
module ssml_tag_escape_stream_core #(
  parameter int QueueDepth = ste_pkg::QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // text_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser   // out_valid, text_done
);

  logic          q_full;
  logic          push;
  logic          pop;
  logic          head_valid;
  ste_pkg::job_t push_job;
  ste_pkg::job_t head_job;

  ste_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  ste_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ste_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

### tb/tb_ssml_tag_escape_stream_core.sv
`timescale 1ns / 1ps

module tb_ssml_tag_escape_stream_core;

  localparam logic [7:0] ESC_BYTE = 8'hEE;
  localparam logic [7:0] HI_MARK = 8'h80;
  localparam logic [7:0] LOW_MASK = 8'h3F;
  localparam int RANDOM_ITEMS = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;
  localparam int DIR_COUNT = 25;

  // held entity prefix
  typedef enum logic [3:0] {
    ENT_NONE, ENT_AMP, ENT_Q, ENT_QU, ENT_QUO, ENT_A, ENT_AP, ENT_APO,
    ENT_AM, ENT_L, ENT_G, ENT_LT, ENT_GT
  } ent_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       run_last;
    logic       done;
  } esc_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
  } text_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       e;
    logic       typed;
    esc_res_t   want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{"A", 1'b0, 1'b1, '{"A", 1'b1, 1'b1, 1'b0}},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}},
    '{ESC_BYTE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
    '{"&", 1'b0, 1'b0, '0},
    '{"q", 1'b0, 1'b0, '0},
    '{"u", 1'b0, 1'b0, '0},
    '{"o", 1'b0, 1'b0, '0},
    '{";", 1'b0, 1'b0, '0},
    '{"&", 1'b0, 1'b0, '0},
    '{"a", 1'b0, 1'b0, '0},
    '{"m", 1'b0, 1'b0, '0},
    '{";", 1'b0, 1'b0, '0},
    '{"&", 1'b0, 1'b0, '0},
    '{"g", 1'b0, 1'b0, '0},
    '{"t", 1'b0, 1'b0, '0},
    '{"<", 1'b0, 1'b0, '0},
    '{"\"", 1'b0, 1'b0, '0},
    '{">", 1'b0, 1'b0, '0},
    '{"\"", 1'b0, 1'b0, '0},
    '{ESC_BYTE, 1'b0, 1'b0, '0},
    '{"x", 1'b0, 1'b0, '0},
    '{"y", 1'b0, 1'b0, '0},
    '{">", 1'b0, 1'b0, '0},
    '{"&", 1'b1, 1'b0, '0}
  };

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  // predictor state
  logic       tag_open = 1'b0;
  logic       sq_open = 1'b0;
  logic       dq_open = 1'b0;
  logic [1:0] skip_cnt = 2'd0;
  ent_t       ent_state = ENT_NONE;

  logic [7:0] step_bytes [$];
  esc_res_t   step_res [$];
  esc_res_t   escaped_q [$];
  text_item_t text_items [$];

  int  bad_cnt = 0;
  int  idle_cycles = 0;
  bit  in_idle = 1'b1;
  bit  out_idle = 1'b1;

  ssml_tag_escape_stream_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function void put(logic [7:0] b);
    step_bytes.push_back(b);
  endfunction

  function void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function void flush_held();
    case (ent_state)
      ENT_AMP: put_str("&");
      ENT_Q:   put_str("&q");
      ENT_QU:  put_str("&qu");
      ENT_QUO: put_str("&quo");
      ENT_A:   put_str("&a");
      ENT_AP:  put_str("&ap");
      ENT_APO: put_str("&apo");
      ENT_AM:  put_str("&am");
      ENT_L:   put_str("&l");
      ENT_G:   put_str("&g");
      ENT_LT:  put_str("&lt");
      ENT_GT:  put_str("&gt");
      default: ;
    endcase
    ent_state = ENT_NONE;
  endfunction

  function void take_fresh(logic [7:0] b);
    if (b == ESC_BYTE) begin
      skip_cnt = 2'd2;
      return;
    end
    if (!tag_open) begin
      if (b == "<") begin
        tag_open = 1'b1;
      end else if (b == "&") begin
        ent_state = ENT_AMP;
        return;
      end else begin
        put(b);
        return;
      end
    end
    put(ESC_BYTE);
    put(HI_MARK | (b >> 6));
    put(HI_MARK | (b & LOW_MASK));
    if (sq_open) begin
      if (b == "'") sq_open = 1'b0;
    end else if (dq_open) begin
      if (b == "\"") dq_open = 1'b0;
    end else if (b == "'") begin
      sq_open = 1'b1;
    end else if (b == "\"") begin
      dq_open = 1'b1;
    end else if (b == ">") begin
      tag_open = 1'b0;
    end
  endfunction

  function void escape_step(logic [7:0] b, logic e);
    ent_t       nxt;
    logic [7:0] done_ch;
    logic       have_ch;
    step_bytes.delete();
    step_res.delete();
    nxt = ENT_NONE;
    have_ch = 1'b0;
    done_ch = 8'h00;
    if (skip_cnt != 2'd0) begin
      skip_cnt = skip_cnt - 2'd1;
    end else if (ent_state != ENT_NONE) begin
      case (ent_state)
        ENT_AMP: begin
          if (b == "q") nxt = ENT_Q;
          else if (b == "a") nxt = ENT_A;
          else if (b == "l") nxt = ENT_L;
          else if (b == "g") nxt = ENT_G;
        end
        ENT_Q:  if (b == "u") nxt = ENT_QU;
        ENT_QU: if (b == "o") nxt = ENT_QUO;
        ENT_A: begin
          if (b == "p") nxt = ENT_AP;
          else if (b == "m") nxt = ENT_AM;
        end
        ENT_AP: if (b == "o") nxt = ENT_APO;
        ENT_L:  if (b == "t") nxt = ENT_LT;
        ENT_G:  if (b == "t") nxt = ENT_GT;
        ENT_QUO: if (b == ";") begin have_ch = 1'b1; done_ch = "\""; end
        ENT_APO: if (b == ";") begin have_ch = 1'b1; done_ch = "'"; end
        ENT_AM:  if (b == ";") begin have_ch = 1'b1; done_ch = "&"; end
        ENT_LT:  if (b == ";") begin have_ch = 1'b1; done_ch = "<"; end
        ENT_GT:  if (b == ";") begin have_ch = 1'b1; done_ch = ">"; end
        default: ;
      endcase
      if (have_ch) begin
        put(done_ch);
        ent_state = ENT_NONE;
      end else if (nxt != ENT_NONE) begin
        ent_state = nxt;
      end else begin
        flush_held();
        take_fresh(b);
      end
    end else begin
      take_fresh(b);
    end
    if (e) begin
      flush_held();
      tag_open = 1'b0;
      sq_open = 1'b0;
      dq_open = 1'b0;
      skip_cnt = 2'd0;
    end
    if (step_bytes.size() == 0) begin
      if (e) step_res.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
    end else begin
      foreach (step_bytes[k]) begin
        step_res.push_back('{step_bytes[k], 1'b1, k == step_bytes.size() - 1,
                             (k == step_bytes.size() - 1) && e});
      end
    end
  endfunction

  function logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return "'";
      1: return "\"";
      2: return ">";
      3: return "<";
      4: return "&";
      5: return ESC_BYTE;
      6: return ";";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function void add_text(logic [7:0] b);
    text_items.push_back('{b, $urandom_range(0, 19) == 0});
  endfunction

  // mostly well-formed entities and tags with random content, plus noise
  function void build_random_text();
    string ents [5];
    string s;
    int    kind;
    int    cut;
    int    n;
    ents = '{"&quot;", "&apos;", "&lt;", "&gt;", "&amp;"};
    while (text_items.size() < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        s = ents[$urandom_range(0, 4)];
        cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, s.len() - 1) : s.len();
        for (int i = 0; i < cut; i++) add_text(s[i]);
        if (cut < s.len()) add_text(pick_byte());
      end else if (kind <= 5) begin
        add_text("<");
        n = $urandom_range(1, 8);
        repeat (n) add_text(pick_byte());
        add_text(">");
      end else if (kind == 6) begin
        add_text(ESC_BYTE);
        add_text(pick_byte());
        add_text(pick_byte());
      end else begin
        add_text(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  task automatic feed(logic [7:0] b, logic e, logic typed, esc_res_t want);
    int gap;
    gap = in_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= e;
    do @(posedge clk); while (!in_tready);
    escape_step(b, e);
    if (typed) begin
      escaped_q.push_back(want);
    end else begin
      foreach (step_res[k]) escaped_q.push_back(step_res[k]);
    end
  endtask

  function void check_out(esc_res_t got);
    esc_res_t want;
    if (escaped_q.size() == 0) begin
      bad_cnt++;
      if (bad_cnt <= MAX_REPORTS)
        $display("unexpected transaction: byte %02h valid %0d last %0d done %0d",
                 got.data, got.valid, got.run_last, got.done);
      return;
    end
    want = escaped_q.pop_front();
    if (got !== want) begin
      bad_cnt++;
      if (bad_cnt <= MAX_REPORTS)
        $display("mismatch: exp %02h/%0d/%0d/%0d got %02h/%0d/%0d/%0d",
                 want.data, want.valid, want.run_last, want.done,
                 got.data, got.valid, got.run_last, got.done);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      check_out('{out_tdata, out_tuser[0], out_tlast, out_tuser[1]});
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ssml_tag_escape_stream_core test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) out_idle = !out_idle;
      gap = out_idle ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin
    text_item_t item;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < DIR_COUNT; i++)
      feed(DIR_ROWS[i].b, DIR_ROWS[i].e, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    build_random_text();
    while (text_items.size() != 0) begin
      if ($urandom_range(0, 39) == 0) in_idle = !in_idle;
      item = text_items.pop_front();
      feed(item.b, item.e, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_cnt == 0) begin
      $display("ssml_tag_escape_stream_core test passed");
    end else begin
      $display("ssml_tag_escape_stream_core test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/ste_pkg.sv
design/ste_front.sv
design/ste_queue.sv
design/ste_back.sv
design/ssml_tag_escape_stream_core.sv
tb/tb_ssml_tag_escape_stream_core.sv
